// File: sv/tve_pkg.sv
// ----------------------------------------------------------------------------
// Touch velocity estimator package
// Shared widths, register indexes and reset values of the estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package tve_pkg;

  // Field widths of the input and result transactions.
  localparam int POS_W   = 16;
  localparam int TIME_W  = 32;
  localparam int TOUCH_W = 4;
  localparam int VEL_W   = 24;

  // Configuration register widths.
  localparam int WIN_W     = 16;
  localparam int MAXV_W    = 23;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VELOCITY = 1'd1;

  // Configuration reset values.
  localparam logic [WIN_W-1:0]  WINDOW_RST = 16'd200;
  localparam logic [MAXV_W-1:0] MAXV_RST   = 23'd256000;

  // Action codes and the touch count that is stored.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;
  localparam logic [TOUCH_W-1:0] SINGLE_TOUCH = 4'd1;

endpackage

`default_nettype wire

// File: sv/tve_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tve_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

// File: sv/tve_divider.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division of a numerator by a 32-bit duration, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tve_divider
  import tve_pkg::*;
#(
  parameter int NUM_W = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [TIME_W-1:0] den,
  output logic                   busy,
  output logic                   done,
  output logic      [NUM_W-1:0]  quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;
  logic [TIME_W-1:0] den_r, den_nxt;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              ge;

  // Trial subtraction of the shifted partial remainder.
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      q_nxt   = {q_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// File: sv/touch_velocity_estimator_unit.sv
// ----------------------------------------------------------------------------
// Touch velocity estimator
// Keeps a ring of recent single-touch samples and reports one clamped x/y
// velocity per input transaction, a running halved average of samples in the window.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+------------------------------
//   in      | input     | in_valid / in_stall    | action, touch_count, x, y, time
//   out     | output    | out_valid / out_stall  | velocity_x, velocity_y
//   cfg     | input     | cfg_wr_en              | cfg_index, cfg_wdata
//
// One transaction makes two passes over the history RAM, a read state and an
// evaluate state per entry, and uses the shared bit-serial divider twice for each
// sample that is divided, once for x and once for y.
// in_stall is high from acceptance until the result is in the output register.
// A result held by out_stall does not block acceptance, only the next result.
// Reset is synchronous and clears the history count and ring pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_velocity_estimator_unit
  import tve_pkg::*;
#(
  parameter int HISTORY_DEPTH = 10,
  parameter int FRAC_BITS     = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_action,
  input  wire logic [TOUCH_W-1:0]       in_touch_count,
  input  wire logic signed [POS_W-1:0]  in_x_position,
  input  wire logic signed [POS_W-1:0]  in_y_position,
  input  wire logic [TIME_W-1:0]        in_time_ms,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [VEL_W-1:0]       out_velocity_x,
  output logic signed [VEL_W-1:0]       out_velocity_y,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [MAXV_W-1:0]        cfg_wdata
);

  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ENT_W  = 2 * POS_W + TIME_W;
  localparam int DIFF_W = POS_W + 1;
  localparam int NUM_W  = POS_W + FRAC_BITS;
  localparam int ACC_W  = NUM_W + 1;
  localparam int CMP_W  = ((ACC_W > VEL_W) ? ACC_W : VEL_W) + 1;

  // Sequencer states.
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_NEWEST_RD = 4'd1;
  localparam logic [3:0] S_NEWEST    = 4'd2;
  localparam logic [3:0] S_P1_RD     = 4'd3;
  localparam logic [3:0] S_P1_EV     = 4'd4;
  localparam logic [3:0] S_P1_END    = 4'd5;
  localparam logic [3:0] S_P2_RD     = 4'd6;
  localparam logic [3:0] S_P2_EV     = 4'd7;
  localparam logic [3:0] S_DIV_GO    = 4'd8;
  localparam logic [3:0] S_DIV       = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  // Ring index wrap for sums below twice the depth.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    if (s >= SUM_W'(HISTORY_DEPTH)) begin
      wrap_idx = IDX_W'(s - SUM_W'(HISTORY_DEPTH));
    end else begin
      wrap_idx = IDX_W'(s);
    end
  endfunction

  // Running average step: load while zero, else halve the sum rounding down.
  function automatic logic signed [ACC_W-1:0] acc_step(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ACC_W-1:0] vel
  );
    logic signed [ACC_W:0] sum;
    sum = {acc[ACC_W-1], acc} + {vel[ACC_W-1], vel};
    if (acc == '0) begin
      acc_step = vel;
    end else begin
      acc_step = sum[ACC_W:1];
    end
  endfunction

  // Clamp to the symmetric limit and narrow to the result width.
  function automatic logic signed [VEL_W-1:0] clamp_vel(
    input logic signed [ACC_W-1:0] acc,
    input logic [MAXV_W-1:0]       maxv
  );
    logic signed [CMP_W-1:0] a;
    logic signed [CMP_W-1:0] m;
    a = CMP_W'(acc);
    m = CMP_W'({1'b0, maxv});
    if (a > m) begin
      clamp_vel = VEL_W'(m);
    end else if (a < -m) begin
      clamp_vel = VEL_W'(-m);
    end else begin
      clamp_vel = VEL_W'(a);
    end
  endfunction

  // Magnitude of a displacement as a divider numerator.
  function automatic logic [NUM_W-1:0] disp_num(input logic signed [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] mag;
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    disp_num = {mag[POS_W-1:0], {FRAC_BITS{1'b0}}};
  endfunction

  logic [3:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         i_r, i_nxt;
  logic [CNT_W-1:0]         kept_r, kept_nxt;
  logic [CNT_W-1:0]         nuse_r, nuse_nxt;
  logic                     sel_y_r, sel_y_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [WIN_W-1:0]         window_r, window_nxt;
  logic [MAXV_W-1:0]        maxv_r, maxv_nxt;

  logic [TIME_W-1:0]        limit_r, limit_nxt;
  logic signed [POS_W-1:0]  x0_r, x0_nxt;
  logic signed [POS_W-1:0]  y0_r, y0_nxt;
  logic [TIME_W-1:0]        t0_r, t0_nxt;
  logic signed [DIFF_W-1:0] dx_r, dx_nxt;
  logic signed [DIFF_W-1:0] dy_r, dy_nxt;
  logic [TIME_W-1:0]        dur_r, dur_nxt;
  logic signed [ACC_W-1:0]  acc_x_r, acc_x_nxt;
  logic signed [ACC_W-1:0]  acc_y_r, acc_y_nxt;
  logic signed [VEL_W-1:0]  vx_r, vx_nxt;
  logic signed [VEL_W-1:0]  vy_r, vy_nxt;

  logic                     in_accept;
  logic                     wr_en;
  logic [IDX_W-1:0]         wr_addr;
  logic [IDX_W-1:0]         newest_idx;
  logic [IDX_W-1:0]         pass_idx;
  logic [IDX_W-1:0]         rd_addr;
  logic [ENT_W-1:0]         rd_data;
  logic signed [POS_W-1:0]  rd_x;
  logic signed [POS_W-1:0]  rd_y;
  logic [TIME_W-1:0]        rd_t;
  logic                     rd_keep;
  logic [TIME_W-1:0]        rd_dur;

  logic                     div_start;
  logic [NUM_W-1:0]         div_num;
  logic                     div_busy;
  logic                     div_done;
  logic [NUM_W-1:0]         div_quot;
  logic                     div_neg;
  logic signed [ACC_W-1:0]  div_vel;

  // Input handshake: one transaction at a time.
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // History write on a single-touch sample.
  assign wr_en   = in_accept && (in_action == ACT_SAMPLE) && (in_touch_count == SINGLE_TOUCH);
  assign wr_addr = (count_r < CNT_W'(HISTORY_DEPTH))
                   ? wrap_idx(SUM_W'(head_r) + SUM_W'(count_r)) : head_r;

  // History read address: newest entry, or the pass position.
  assign newest_idx = wrap_idx(SUM_W'(head_r) + SUM_W'(count_r) - SUM_W'(1));
  assign pass_idx   = wrap_idx(SUM_W'(head_r) + SUM_W'(i_r));
  assign rd_addr    = (state_r == S_NEWEST_RD) ? newest_idx : pass_idx;

  tve_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_x_position, in_y_position, in_time_ms}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_x    = rd_data[ENT_W-1 -: POS_W];
  assign rd_y    = rd_data[TIME_W +: POS_W];
  assign rd_t    = rd_data[TIME_W-1:0];
  assign rd_keep = (rd_t >= limit_r);
  assign rd_dur  = rd_t - t0_r;

  // Shared divider: x numerator when started from S_DIV_GO, y from S_DIV.
  assign div_num = disp_num((state_r == S_DIV) ? dy_r : dx_r);
  assign div_neg = sel_y_r ? dy_r[DIFF_W-1] : dx_r[DIFF_W-1];
  assign div_vel = div_neg ? -ACC_W'(div_quot) : ACC_W'(div_quot);

  tve_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dur_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    i_nxt         = i_r;
    kept_nxt      = kept_r;
    nuse_nxt      = nuse_r;
    sel_y_nxt     = sel_y_r;
    out_valid_nxt = out_valid_r;
    window_nxt    = window_r;
    maxv_nxt      = maxv_r;
    limit_nxt     = limit_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    t0_nxt        = t0_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dur_nxt       = dur_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    div_start     = 1'b0;

    // Configuration writes.
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WINDOW_MS:    window_nxt = cfg_wdata[WIN_W-1:0];
        CFG_MAX_VELOCITY: maxv_nxt   = cfg_wdata;
        default:          ;
      endcase
    end

    // The output register empties when the result transaction completes.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_action == ACT_CLEAR) begin
            count_nxt = '0;
            head_nxt  = '0;
          end else if (in_touch_count == SINGLE_TOUCH) begin
            if (count_r < CNT_W'(HISTORY_DEPTH)) begin
              count_nxt = count_r + CNT_W'(1);
            end else begin
              head_nxt = wrap_idx(SUM_W'(head_r) + SUM_W'(1));
            end
          end
          acc_x_nxt = '0;
          acc_y_nxt = '0;
          state_nxt = S_NEWEST_RD;
        end
      end
      S_NEWEST_RD: begin
        state_nxt = (count_r == '0) ? S_OUT : S_NEWEST;
      end
      S_NEWEST: begin
        limit_nxt = (rd_t > TIME_W'(window_r)) ? rd_t - TIME_W'(window_r) : '0;
        i_nxt     = '0;
        kept_nxt  = '0;
        state_nxt = S_P1_RD;
      end
      S_P1_RD: begin
        state_nxt = S_P1_EV;
      end
      S_P1_EV: begin
        // Count the kept samples and latch the oldest one.
        if (rd_keep) begin
          kept_nxt = kept_r + CNT_W'(1);
          if (kept_r == '0) begin
            x0_nxt = rd_x;
            y0_nxt = rd_y;
            t0_nxt = rd_t;
          end
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = (i_r + CNT_W'(1) == count_r) ? S_P1_END : S_P1_RD;
      end
      S_P1_END: begin
        nuse_nxt  = (kept_r > CNT_W'(3)) ? kept_r - CNT_W'(1) : kept_r;
        i_nxt     = '0;
        kept_nxt  = '0;
        state_nxt = (kept_r < CNT_W'(2)) ? S_OUT : S_P2_RD;
      end
      S_P2_RD: begin
        state_nxt = S_P2_EV;
      end
      S_P2_EV: begin
        // Later kept samples are measured against the oldest kept one.
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_P2_RD;
        if (rd_keep) begin
          kept_nxt = kept_r + CNT_W'(1);
          if (kept_r != '0) begin
            dur_nxt = rd_dur;
            dx_nxt  = DIFF_W'(rd_x) - DIFF_W'(x0_r);
            dy_nxt  = DIFF_W'(rd_y) - DIFF_W'(y0_r);
            if (rd_dur != '0) begin
              state_nxt = S_DIV_GO;
            end else if (kept_r + CNT_W'(1) == nuse_r) begin
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        sel_y_nxt = 1'b0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (!sel_y_r) begin
            acc_x_nxt = acc_step(acc_x_r, div_vel);
            div_start = 1'b1;
            sel_y_nxt = 1'b1;
          end else begin
            acc_y_nxt = acc_step(acc_y_r, div_vel);
            state_nxt = (kept_r == nuse_r) ? S_OUT : S_P2_RD;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          vx_nxt        = clamp_vel(acc_x_r, maxv_r);
          vy_nxt        = clamp_vel(acc_y_r, maxv_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      i_r         <= '0;
      kept_r      <= '0;
      nuse_r      <= '0;
      sel_y_r     <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RST;
      maxv_r      <= MAXV_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      i_r         <= i_nxt;
      kept_r      <= kept_nxt;
      nuse_r      <= nuse_nxt;
      sel_y_r     <= sel_y_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
      maxv_r      <= maxv_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    x0_r    <= x0_nxt;
    y0_r    <= y0_nxt;
    t0_r    <= t0_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    dur_r   <= dur_nxt;
    acc_x_r <= acc_x_nxt;
    acc_y_r <= acc_y_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_velocity_x = vx_r;
  assign out_velocity_y = vy_r;

  // The fill count never exceeds the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HISTORY_DEPTH))
    else $error("history count exceeds depth");

  // The ring pointer stays inside the ring.
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < IDX_W'(HISTORY_DEPTH))
    else $error("history head out of range");

  // A clear transaction empties the history.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_action == ACT_CLEAR)) |=> (count_r == '0))
    else $error("clear did not empty the history");

  // The divider is only started when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

endmodule

`default_nettype wire
